// ----- rtl/core/tsn_pkg.sv -----
// Package for the telnet server negotiator: byte codes, command and
// destination codes, parse phase encoding and the result entry type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tsn_pkg;

    localparam logic [7:0] IAC_B    = 8'd255;
    localparam logic [7:0] SE_B     = 8'd240;
    localparam logic [7:0] SB_B     = 8'd250;
    localparam logic [7:0] WILL_B   = 8'd251;
    localparam logic [7:0] DMARK_B  = 8'd242;
    localparam logic [7:0] IP_B     = 8'd244;
    localparam logic [7:0] AO_B     = 8'd245;
    localparam logic [7:0] EC_B     = 8'd247;
    localparam logic [7:0] EL_B     = 8'd248;
    localparam logic [7:0] GA_B     = 8'd249;
    localparam logic [7:0] CR_B     = 8'd13;
    localparam logic [7:0] LF_B     = 8'd10;
    localparam logic [7:0] NUL_B    = 8'd0;
    localparam logic [7:0] ASCII_MASK = 8'o177;

    localparam logic [7:0] OPT_BINARY = 8'd0;
    localparam logic [7:0] OPT_ECHO   = 8'd1;
    localparam logic [7:0] OPT_SGA    = 8'd3;
    localparam logic [7:0] OPT_SNDLOC = 8'd23;

    localparam logic [1:0] CMD_NET  = 2'd0;
    localparam logic [1:0] CMD_TERM = 2'd1;
    localparam logic [1:0] CMD_IDLE = 2'd2;

    localparam logic [1:0] DEST_TERM  = 2'd0;
    localparam logic [1:0] DEST_NET   = 2'd1;
    localparam logic [1:0] DEST_FLUSH = 2'd2;

    localparam logic [1:0] VERB_WILL = 2'd0;
    localparam logic [1:0] VERB_WONT = 2'd1;
    localparam logic [1:0] VERB_DO   = 2'd2;
    localparam logic [1:0] VERB_DONT = 2'd3;

    localparam logic [1:0] REG_ERASE = 2'd0;
    localparam logic [1:0] REG_KILL  = 2'd1;
    localparam logic [1:0] REG_INTR  = 2'd2;
    localparam logic [1:0] REG_FLUSH = 2'd3;

    localparam logic [7:0] ERASE_RST = 8'd127;
    localparam logic [7:0] KILL_RST  = 8'd21;
    localparam logic [7:0] INTR_RST  = 8'd3;
    localparam logic [7:0] FLUSH_RST = 8'd15;

    localparam int MAX_RESULTS = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [4:0] {
        PH_DATA   = 5'b00001,
        PH_IAC    = 5'b00010,
        PH_OPT    = 5'b00100,
        PH_SBOPT  = 5'b01000,
        PH_SBSKIP = 5'b10000
    } phase_t;

    typedef struct packed {
        logic [1:0] destination;
        logic [7:0] out_byte;
        logic       last;
        logic       local_echo;
    } result_t;

endpackage

`default_nettype wire

// ----- rtl/core/telnet_server_negotiator.sv -----
// Telnet server negotiator top level: IAC parser, option negotiation and
// a four-entry result queue. Depends on tsn_pkg.
// Accepted requests write their results into the queue, offered from its head.
// Throughput: one request per cycle while each yields at most one result and
// m_ready is high; multi-result requests drain one result per cycle through
// the queue while m_ready is high; s_ready is low while more than one is queued.
// Reset (aresetn low, synchronous): parser to data phase, flags and CR marks
// cleared, queue emptied, character registers back to their defaults.
`timescale 1ns / 1ps
`default_nettype none

module telnet_server_negotiator (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [1:0] s_command,
    input  wire logic [7:0] s_data_byte,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [1:0]      m_destination,
    output logic [7:0]      m_out_byte,
    output logic            m_last,
    output logic            m_local_echo,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [1:0] cfg_index,
    input  wire logic [7:0] cfg_data
);
    import tsn_pkg::*;

    logic [7:0] erase_reg, kill_reg, intr_reg, flush_reg;
    phase_t     phase_reg, phase_next;
    logic [1:0] verb_reg, verb_next;
    logic [3:0] rflags_reg, rflags_next;
    logic [2:0] lflags_reg, lflags_next;
    logic       rx_cr_reg, rx_cr_next;
    logic       tx_cr_reg, tx_cr_next;

    result_t          queue_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] head_reg, tail_reg;
    logic [CNT_W-1:0] count_reg;

    logic       accept, pop;
    logic [1:0] n_res;
    logic [1:0] res_dest [MAX_RESULTS];
    logic [7:0] res_byte [MAX_RESULTS];

    logic [3:0] rmask;
    logic [2:0] lmask;
    logic       r_known, l_known, r_held, l_held;
    logic       neg_ok;
    logic [1:0] neg_reply;
    logic [3:0] neg_rflags;
    logic [2:0] neg_lflags;
    logic [7:0] tb;

    assign cfg_ready = 1'b1;
    assign s_ready   = count_reg <= CNT_W'(QUEUE_DEPTH - MAX_RESULTS);
    assign accept    = s_valid && s_ready;
    assign m_valid   = count_reg != '0;
    assign pop       = m_valid && m_ready;

    assign m_destination = queue_reg[head_reg].destination;
    assign m_out_byte    = queue_reg[head_reg].out_byte;
    assign m_last        = queue_reg[head_reg].last;
    assign m_local_echo  = queue_reg[head_reg].local_echo;

    // option negotiation
    always_comb begin
        rmask = 4'b0000;
        lmask = 3'b000;
        case (s_data_byte)
            OPT_BINARY: begin rmask = 4'b0001; lmask = 3'b001; end
            OPT_ECHO:   begin rmask = 4'b0010; lmask = 3'b010; end
            OPT_SGA:    begin rmask = 4'b0100; lmask = 3'b100; end
            OPT_SNDLOC: begin rmask = 4'b1000; end
            default:    begin rmask = 4'b0000; lmask = 3'b000; end
        endcase
        r_known    = |rmask;
        l_known    = |lmask;
        r_held     = |(rflags_reg & rmask);
        l_held     = |(lflags_reg & lmask);
        neg_ok     = 1'b0;
        neg_reply  = VERB_WILL;
        neg_rflags = rflags_reg;
        neg_lflags = lflags_reg;
        case (verb_reg)
            VERB_WILL: begin
                if (!(r_known && r_held)) begin
                    neg_ok = 1'b1;
                    if (s_data_byte inside {OPT_BINARY, OPT_SGA, OPT_SNDLOC}) begin
                        neg_rflags = rflags_reg | rmask;
                        neg_reply  = VERB_DO;
                    end else begin
                        neg_reply = VERB_DONT;
                    end
                end
            end
            VERB_WONT: begin
                if (r_known && r_held) begin
                    neg_ok    = 1'b1;
                    neg_reply = VERB_DONT;
                    if (s_data_byte inside {OPT_BINARY, OPT_SGA}) begin
                        neg_rflags = rflags_reg & ~rmask;
                    end
                end
            end
            VERB_DO: begin
                if (!(l_known && l_held)) begin
                    neg_ok = 1'b1;
                    if (!l_known) begin
                        neg_reply = VERB_WONT;
                    end else begin
                        neg_reply  = VERB_WILL;
                        neg_lflags = lflags_reg | lmask;
                        if (s_data_byte == OPT_ECHO) begin
                            neg_rflags = rflags_reg & ~4'b0010;
                        end
                    end
                end
            end
            default: begin
                if (l_known && l_held) begin
                    neg_ok     = 1'b1;
                    neg_reply  = VERB_WONT;
                    neg_lflags = lflags_reg & ~lmask;
                    if (s_data_byte == OPT_ECHO) begin
                        neg_rflags = rflags_reg | 4'b0010;
                    end
                end
            end
        endcase
    end

    // per-request step
    always_comb begin
        phase_next  = phase_reg;
        verb_next   = verb_reg;
        rflags_next = rflags_reg;
        lflags_next = lflags_reg;
        rx_cr_next  = rx_cr_reg;
        tx_cr_next  = tx_cr_reg;
        n_res       = 2'd0;
        for (int k = 0; k < MAX_RESULTS; k++) begin
            res_dest[k] = DEST_TERM;
            res_byte[k] = NUL_B;
        end
        tb = lflags_reg[0] ? s_data_byte : (s_data_byte & ASCII_MASK);
        if (accept) begin
            case (s_command)
                CMD_NET: begin
                    case (phase_reg)
                        PH_IAC: begin
                            phase_next = PH_DATA;
                            if (s_data_byte == IAC_B) begin
                                n_res       = 2'd1;
                                res_dest[0] = DEST_TERM;
                                res_byte[0] = IAC_B;
                                rx_cr_next  = 1'b0;
                            end else if (s_data_byte >= WILL_B) begin
                                verb_next  = 2'(s_data_byte - WILL_B);
                                phase_next = PH_OPT;
                            end else if (s_data_byte == SB_B) begin
                                phase_next = PH_SBOPT;
                            end else if (s_data_byte == DMARK_B) begin
                                n_res       = 2'd1;
                                res_dest[0] = DEST_FLUSH;
                            end else if (s_data_byte == IP_B) begin
                                n_res       = 2'd1;
                                res_byte[0] = intr_reg;
                            end else if (s_data_byte == EC_B) begin
                                n_res       = 2'd1;
                                res_byte[0] = erase_reg;
                            end else if (s_data_byte == EL_B) begin
                                n_res       = 2'd1;
                                res_byte[0] = kill_reg;
                            end else if (s_data_byte == AO_B) begin
                                n_res       = 2'd3;
                                res_dest[0] = DEST_NET;
                                res_byte[0] = IAC_B;
                                res_dest[1] = DEST_NET;
                                res_byte[1] = DMARK_B;
                                res_byte[2] = flush_reg;
                            end
                        end
                        PH_OPT: begin
                            phase_next  = PH_DATA;
                            rflags_next = neg_rflags;
                            lflags_next = neg_lflags;
                            if (neg_ok) begin
                                n_res       = 2'd3;
                                res_dest[0] = DEST_NET;
                                res_byte[0] = IAC_B;
                                res_dest[1] = DEST_NET;
                                res_byte[1] = 8'(WILL_B + {6'd0, neg_reply});
                                res_dest[2] = DEST_NET;
                                res_byte[2] = s_data_byte;
                            end
                        end
                        PH_SBOPT: begin
                            phase_next = (s_data_byte == OPT_SNDLOC) ? PH_SBSKIP : PH_DATA;
                        end
                        PH_SBSKIP: begin
                            if (s_data_byte == SE_B) begin
                                phase_next = PH_DATA;
                            end
                        end
                        default: begin
                            phase_next = PH_DATA;
                            if (s_data_byte == IAC_B) begin
                                phase_next = PH_IAC;
                            end else begin
                                if (!(rx_cr_reg && (s_data_byte == LF_B ||
                                                    s_data_byte == NUL_B))) begin
                                    n_res       = 2'd1;
                                    res_byte[0] = s_data_byte;
                                end
                                rx_cr_next = s_data_byte == CR_B;
                            end
                        end
                    endcase
                end
                CMD_TERM: begin
                    if (tx_cr_reg && tb != LF_B) begin
                        n_res       = 2'd2;
                        res_dest[0] = DEST_NET;
                        res_byte[0] = NUL_B;
                        res_dest[1] = DEST_NET;
                        res_byte[1] = tb;
                    end else begin
                        n_res       = 2'd1;
                        res_dest[0] = DEST_NET;
                        res_byte[0] = tb;
                    end
                    tx_cr_next = tb == CR_B;
                end
                CMD_IDLE: begin
                    case (phase_reg)
                        PH_IAC, PH_OPT, PH_SBOPT, PH_SBSKIP: begin
                        end
                        default: begin
                            phase_next = PH_DATA;
                            if (!lflags_reg[2]) begin
                                n_res       = 2'd2;
                                res_dest[0] = DEST_NET;
                                res_byte[0] = IAC_B;
                                res_dest[1] = DEST_NET;
                                res_byte[1] = GA_B;
                            end
                        end
                    endcase
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            erase_reg  <= ERASE_RST;
            kill_reg   <= KILL_RST;
            intr_reg   <= INTR_RST;
            flush_reg  <= FLUSH_RST;
            phase_reg  <= PH_DATA;
            verb_reg   <= VERB_WILL;
            rflags_reg <= '0;
            lflags_reg <= '0;
            rx_cr_reg  <= 1'b0;
            tx_cr_reg  <= 1'b0;
            head_reg   <= '0;
            tail_reg   <= '0;
            count_reg  <= '0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    REG_ERASE: erase_reg <= cfg_data;
                    REG_KILL:  kill_reg  <= cfg_data;
                    REG_INTR:  intr_reg  <= cfg_data;
                    REG_FLUSH: flush_reg <= cfg_data;
                    default:   erase_reg <= erase_reg;
                endcase
            end
            phase_reg  <= phase_next;
            verb_reg   <= verb_next;
            rflags_reg <= rflags_next;
            lflags_reg <= lflags_next;
            rx_cr_reg  <= rx_cr_next;
            tx_cr_reg  <= tx_cr_next;
            if (pop) begin
                head_reg <= head_reg + PTR_W'(1);
            end
            tail_reg  <= tail_reg + PTR_W'(n_res);
            count_reg <= count_reg + CNT_W'(n_res) - CNT_W'(pop);
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < MAX_RESULTS; k++) begin
            if (2'(k) < n_res) begin
                queue_reg[PTR_W'(int'(tail_reg) + k)] <= '{
                    destination: res_dest[k],
                    out_byte:    res_byte[k],
                    last:        2'(k + 1) == n_res,
                    local_echo:  lflags_next[1]
                };
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/tsn_checker.sv -----
// Port-level checker for the telnet server negotiator, bound to the top level.
// Depends on tsn_pkg and telnet_server_negotiator.
`timescale 1ns / 1ps
`default_nettype none

module tsn_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic [1:0] m_destination,
    input wire logic [7:0] m_out_byte,
    input wire logic       cfg_ready
);
    import tsn_pkg::*;

    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result offered right after reset");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_byte) && $stable(m_destination))
        else $error("stalled result changed");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_destination == DEST_FLUSH |-> m_out_byte == NUL_B)
        else $error("flush request carries a nonzero byte");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_destination == DEST_TERM || m_destination == DEST_NET ||
                    m_destination == DEST_FLUSH)
        else $error("undefined destination");

    assert property (@(posedge aclk) disable iff (!aresetn) cfg_ready)
        else $error("configuration port stalled");

endmodule

bind telnet_server_negotiator tsn_checker u_tsn_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_destination (m_destination),
    .m_out_byte    (m_out_byte),
    .cfg_ready     (cfg_ready)
);

`default_nettype wire

// ----- bench/tb_telnet_server_negotiator.sv -----
// Testbench for telnet_server_negotiator: directed and random request streams,
// checked result by result against an in-bench model of the negotiator.
// Depends on tsn_pkg and the telnet_server_negotiator RTL.
`timescale 1ns / 1ps

module tb_telnet_server_negotiator;
    import tsn_pkg::*;

    localparam logic [7:0] OPT_TMARK  = 8'd6;
    localparam logic [7:0] OPT_TTYPE  = 8'd24;
    localparam logic [7:0] NOP_B      = 8'd241;
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int BINARY_BIT    = 0;
    localparam int ECHO_BIT      = 1;
    localparam int SGA_BIT       = 2;
    localparam int SETTLE_CYCLES = 4;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [1:0] s_command = CMD_NET;
    logic [7:0] s_data_byte = 8'd0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [1:0] m_destination;
    logic [7:0] m_out_byte;
    logic       m_last;
    logic       m_local_echo;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [1:0] cfg_index = REG_ERASE;
    logic [7:0] cfg_data = 8'd0;

    telnet_server_negotiator u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command     (s_command),
        .s_data_byte   (s_data_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_destination (m_destination),
        .m_out_byte    (m_out_byte),
        .m_last        (m_last),
        .m_local_echo  (m_local_echo),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // model state
    phase_t     parse_state;
    logic [1:0] held_verb;
    logic [3:0] remote_opts;
    logic [2:0] local_opts;
    logic       net_saw_cr;
    logic       term_saw_cr;
    logic [7:0] erase_ch, kill_ch, intr_ch, flush_ch;

    result_t reply_buf [MAX_RESULTS];
    int      reply_n;
    result_t pending_replies [$];
    result_t oldest_reply;

    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    int request_count = 0;
    int reply_count = 0;
    int reg_write_count = 0;
    int error_count = 0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #1_000_000;
        $display("[telnet_server_negotiator] ERROR");
        $finish;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            reply_count++;
            if (pending_replies.size() == 0) begin
                $error("result with none expected: dest %0d byte %0d",
                       m_destination, m_out_byte);
                error_count++;
            end else begin
                oldest_reply = pending_replies.pop_front();
                if (m_destination !== oldest_reply.destination) begin
                    $error("destination: expected %0d, actual %0d",
                           oldest_reply.destination, m_destination);
                    error_count++;
                end
                if (m_out_byte !== oldest_reply.out_byte) begin
                    $error("out_byte: expected %0d, actual %0d",
                           oldest_reply.out_byte, m_out_byte);
                    error_count++;
                end
                if (m_last !== oldest_reply.last) begin
                    $error("last: expected %0d, actual %0d", oldest_reply.last, m_last);
                    error_count++;
                end
                if (m_local_echo !== oldest_reply.local_echo) begin
                    $error("local_echo: expected %0d, actual %0d",
                           oldest_reply.local_echo, m_local_echo);
                    error_count++;
                end
            end
        end
    end

    function automatic void reset_model();
        parse_state = PH_DATA;
        held_verb   = VERB_WILL;
        remote_opts = '0;
        local_opts  = '0;
        net_saw_cr  = 1'b0;
        term_saw_cr = 1'b0;
        erase_ch    = ERASE_RST;
        kill_ch     = KILL_RST;
        intr_ch     = INTR_RST;
        flush_ch    = FLUSH_RST;
    endfunction

    function automatic void add_reply(input logic [1:0] dest, input logic [7:0] value);
        if (reply_n < MAX_RESULTS) begin
            reply_buf[reply_n].destination = dest;
            reply_buf[reply_n].out_byte    = value;
            reply_n++;
        end
    endfunction

    function automatic int remote_index(input logic [7:0] opt);
        case (opt)
            OPT_BINARY: return BINARY_BIT;
            OPT_ECHO:   return ECHO_BIT;
            OPT_SGA:    return SGA_BIT;
            OPT_SNDLOC: return 3;
            default:    return -1;
        endcase
    endfunction

    function automatic int local_index(input logic [7:0] opt);
        case (opt)
            OPT_BINARY: return BINARY_BIT;
            OPT_ECHO:   return ECHO_BIT;
            OPT_SGA:    return SGA_BIT;
            default:    return -1;
        endcase
    endfunction

    function automatic bit negotiate(input logic [1:0] verb, input logic [7:0] opt,
                                     output logic [1:0] reply);
        int rb;
        int lb;
        rb = remote_index(opt);
        lb = local_index(opt);
        reply = VERB_WILL;
        case (verb)
            VERB_WILL: begin
                if (rb >= 0 && remote_opts[rb]) return 1'b0;
                if (opt == OPT_BINARY || opt == OPT_SGA || opt == OPT_SNDLOC) begin
                    remote_opts[rb] = 1'b1;
                    reply = VERB_DO;
                end else begin
                    reply = VERB_DONT;
                end
                return 1'b1;
            end
            VERB_WONT: begin
                if (rb < 0 || !remote_opts[rb]) return 1'b0;
                if (opt == OPT_BINARY || opt == OPT_SGA) remote_opts[rb] = 1'b0;
                reply = VERB_DONT;
                return 1'b1;
            end
            VERB_DO: begin
                if (lb >= 0 && local_opts[lb]) return 1'b0;
                if (lb < 0) begin
                    reply = VERB_WONT;
                    return 1'b1;
                end
                local_opts[lb] = 1'b1;
                if (opt == OPT_ECHO) remote_opts[ECHO_BIT] = 1'b0;
                reply = VERB_WILL;
                return 1'b1;
            end
            default: begin
                if (lb < 0 || !local_opts[lb]) return 1'b0;
                local_opts[lb] = 1'b0;
                if (opt == OPT_ECHO) remote_opts[ECHO_BIT] = 1'b1;
                reply = VERB_WONT;
                return 1'b1;
            end
        endcase
    endfunction

    function automatic void net_data(input logic [7:0] value);
        if (!(net_saw_cr && (value == LF_B || value == NUL_B))) add_reply(DEST_TERM, value);
        net_saw_cr = (value == CR_B);
    endfunction

    function automatic void compute_replies(input logic [1:0] cmd, input logic [7:0] data);
        logic [1:0] reply;
        logic [7:0] tx_byte;
        reply_n = 0;
        case (cmd)
            CMD_NET: begin
                case (parse_state)
                    PH_IAC: begin
                        parse_state = PH_DATA;
                        if (data == IAC_B) begin
                            net_data(data);
                        end else if (data >= WILL_B) begin
                            held_verb   = 2'(data - WILL_B);
                            parse_state = PH_OPT;
                        end else if (data == SB_B) begin
                            parse_state = PH_SBOPT;
                        end else if (data == DMARK_B) begin
                            add_reply(DEST_FLUSH, NUL_B);
                        end else if (data == IP_B) begin
                            add_reply(DEST_TERM, intr_ch);
                        end else if (data == EC_B) begin
                            add_reply(DEST_TERM, erase_ch);
                        end else if (data == EL_B) begin
                            add_reply(DEST_TERM, kill_ch);
                        end else if (data == AO_B) begin
                            add_reply(DEST_NET, IAC_B);
                            add_reply(DEST_NET, DMARK_B);
                            add_reply(DEST_TERM, flush_ch);
                        end
                    end
                    PH_OPT: begin
                        parse_state = PH_DATA;
                        if (negotiate(held_verb, data, reply)) begin
                            add_reply(DEST_NET, IAC_B);
                            add_reply(DEST_NET, WILL_B + {6'd0, reply});
                            add_reply(DEST_NET, data);
                        end
                    end
                    PH_SBOPT: begin
                        parse_state = (data == OPT_SNDLOC) ? PH_SBSKIP : PH_DATA;
                    end
                    PH_SBSKIP: begin
                        if (data == SE_B) parse_state = PH_DATA;
                    end
                    default: begin
                        parse_state = PH_DATA;
                        if (data == IAC_B) parse_state = PH_IAC;
                        else net_data(data);
                    end
                endcase
            end
            CMD_TERM: begin
                tx_byte = local_opts[BINARY_BIT] ? data : (data & ASCII_MASK);
                if (term_saw_cr && tx_byte != LF_B) add_reply(DEST_NET, NUL_B);
                add_reply(DEST_NET, tx_byte);
                term_saw_cr = (tx_byte == CR_B);
            end
            CMD_IDLE: begin
                if (parse_state == PH_DATA && !local_opts[SGA_BIT]) begin
                    add_reply(DEST_NET, IAC_B);
                    add_reply(DEST_NET, GA_B);
                end
            end
            default: ;
        endcase
        for (int k = 0; k < reply_n; k++) begin
            reply_buf[k].last       = (k == reply_n - 1);
            reply_buf[k].local_echo = local_opts[ECHO_BIT];
            pending_replies.push_back(reply_buf[k]);
        end
    endfunction

    task automatic send_request(input logic [1:0] cmd, input logic [7:0] data);
        if ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < sender_idle_pct);
        end
        s_valid     <= 1'b1;
        s_command   <= cmd;
        s_data_byte <= data;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        compute_replies(cmd, data);
        request_count++;
    endtask

    task automatic send_iac_cmd(input logic [7:0] code);
        send_request(CMD_NET, IAC_B);
        send_request(CMD_NET, code);
    endtask

    task automatic send_option(input logic [1:0] verb, input logic [7:0] opt);
        send_request(CMD_NET, IAC_B);
        send_request(CMD_NET, WILL_B + {6'd0, verb});
        send_request(CMD_NET, opt);
    endtask

    task automatic drain_replies();
        s_valid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
        drain_replies();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            REG_ERASE: erase_ch = value;
            REG_KILL:  kill_ch  = value;
            REG_INTR:  intr_ch  = value;
            default:   flush_ch = value;
        endcase
        reg_write_count++;
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic load_random_chars();
        write_reg(REG_ERASE, 8'($urandom));
        write_reg(REG_KILL, 8'($urandom));
        write_reg(REG_INTR, 8'($urandom));
        write_reg(REG_FLUSH, 8'($urandom));
    endtask

    function automatic logic [7:0] pick_net_byte();
        case ($urandom_range(7))
            0:       return CR_B;
            1:       return LF_B;
            2:       return NUL_B;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] pick_term_byte();
        case ($urandom_range(5))
            0:       return CR_B;
            1:       return LF_B;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] pick_option();
        case ($urandom_range(7))
            0, 1:    return OPT_BINARY;
            2:       return OPT_ECHO;
            3:       return OPT_SGA;
            4:       return OPT_SNDLOC;
            5:       return OPT_TMARK;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] pick_command_byte();
        case ($urandom_range(10))
            0:       return IP_B;
            1:       return AO_B;
            2:       return EC_B;
            3:       return EL_B;
            4:       return DMARK_B;
            5:       return IAC_B;
            6:       return GA_B;
            7:       return NOP_B;
            8:       return SE_B;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic test_net_commands();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        send_request(CMD_NET, 8'h00);
        send_request(CMD_NET, CR_B);
        send_request(CMD_NET, NUL_B);
        send_request(CMD_NET, IAC_B);
        send_request(CMD_IDLE, 8'hFF);
        send_request(CMD_NET, NOP_B);
        send_iac_cmd(IAC_B);
        send_iac_cmd(AO_B);
        send_iac_cmd(DMARK_B);
        send_iac_cmd(SB_B);
        send_request(CMD_NET, OPT_SNDLOC);
        send_request(CMD_NET, IAC_B);
        send_request(CMD_NET, SE_B);
        send_iac_cmd(SB_B);
        send_request(CMD_NET, OPT_TTYPE);
        drain_replies();
    endtask

    task automatic test_option_replies();
        send_option(VERB_DO, OPT_ECHO);
        send_option(VERB_DONT, OPT_ECHO);
        send_option(VERB_WONT, OPT_ECHO);
        send_option(VERB_DO, OPT_BINARY);
        send_option(VERB_WILL, OPT_TMARK);
        drain_replies();
    endtask

    task automatic test_terminal_path();
        send_request(CMD_TERM, 8'hFF);
        send_request(CMD_TERM, CR_B);
        send_request(CMD_TERM, 8'h78);
        send_request(CMD_IDLE, 8'h00);
        send_request(CMD_UNUSED, 8'hA5);
        drain_replies();
    endtask

    task automatic test_char_registers();
        logic [7:0] value;
        sender_idle_pct    = 35;
        receiver_stall_pct = 35;
        for (int pass = 0; pass < 3; pass++) begin
            value = (pass == 0) ? 8'h00 : (pass == 1) ? 8'hFF : 8'($urandom);
            write_reg(REG_ERASE, value);
            write_reg(REG_KILL, ~value);
            write_reg(REG_INTR, value);
            write_reg(REG_FLUSH, ~value);
            send_iac_cmd(IP_B);
            send_iac_cmd(EC_B);
            send_iac_cmd(EL_B);
            send_iac_cmd(AO_B);
        end
        drain_replies();
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input int n_items, input bit pause_midway);
        int  sent;
        int  kind;
        int  span;
        bit  paused;
        logic [7:0] opt;
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        sent   = 0;
        paused = 1'b0;
        while (sent < n_items) begin
            if (pause_midway && !paused && sent >= n_items / 2) begin
                drain_replies();
                paused = 1'b1;
            end
            kind = $urandom_range(99);
            if (kind < 30) begin
                send_request(CMD_NET, pick_net_byte());
                sent++;
            end else if (kind < 50) begin
                send_request(CMD_TERM, pick_term_byte());
                sent++;
            end else if (kind < 75) begin
                send_option(2'($urandom_range(3)), pick_option());
                sent += 3;
            end else if (kind < 87) begin
                send_iac_cmd(pick_command_byte());
                sent += 2;
            end else if (kind < 93) begin
                opt = ($urandom_range(3) == 0) ? 8'($urandom) : OPT_SNDLOC;
                send_iac_cmd(SB_B);
                send_request(CMD_NET, opt);
                sent += 3;
                if (opt == OPT_SNDLOC) begin
                    span = $urandom_range(4);
                    repeat (span) send_request(CMD_NET, 8'($urandom));
                    // leave the skip open now and then
                    if ($urandom_range(7) != 0) send_request(CMD_NET, SE_B);
                end
            end else if (kind < 98) begin
                send_request(CMD_IDLE, 8'($urandom));
                sent++;
            end else begin
                send_request(CMD_UNUSED, 8'($urandom));
            end
        end
        drain_replies();
    endtask

    initial begin
        reset_model();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_net_commands();
        test_option_replies();
        test_terminal_path();
        test_char_registers();
        test_random_traffic(0, 0, 70, 1'b0);
        load_random_chars();
        test_random_traffic(48, 0, 70, 1'b1);
        load_random_chars();
        test_random_traffic(0, 48, 70, 1'b0);
        load_random_chars();
        test_random_traffic(35, 35, 70, 1'b0);
        drain_replies();
        $display("Covered %0d requests and %0d results over four idle/stall mixes,",
                 request_count, reply_count);
        $display("with %0d character register writes including all-zero and all-one.",
                 reg_write_count);
        if (error_count == 0) begin
            $display("[telnet_server_negotiator] OK");
        end else begin
            $display("[telnet_server_negotiator] ERROR");
        end
        $finish;
    end

endmodule
